### hdl/ffha_pkg.sv
// ============================================================================
// ffha_pkg: shared types and codes of the first-fit heap allocator
// Request and result beats, register indexes, status codes, controller
// states and the command/status bundles between controller and datapath.
// ============================================================================
package ffha_pkg;

    // Field widths fixed by the block's interface.
    localparam int SIZE_W     = 16;
    localparam int ADDR_W     = 32;
    localparam int LIMIT_W    = 17;
    localparam int MINBLK_W   = 13;
    localparam int SZ8_W      = 17;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLOCK  = 2'd2;

    // Register reset values.
    localparam logic [LIMIT_W-1:0]  HEAP_LIMIT_RST = 17'h10000;
    localparam logic [MINBLK_W-1:0] MIN_BLOCK_RST  = 13'd16;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_REUSED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OOM      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FREED    = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0]   data_address;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_WALK,
        S_SPLIT,
        S_TAIL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                accept;
        logic                free_wr;
        logic                advance;
        logic                take;
        logic                split_wr;
        logic                append;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_end;
        logic fit;
        logic split;
        logic room;
    } t_sts;

endpackage

### hdl/first_fit_heap_allocator_top.sv
// Sequence: a free writes its flag in S_FREE and issues the result beat; an allocate walks
// the headers first fit and issues an unsplit reuse from S_WALK, and a split, append or
// out of memory from S_SPLIT or S_TAIL. The result beat is registered.
// Throughput: one header per cycle, set by the size memory read feeding the next offset.
// Reset is synchronous, active low: it restores the registers and clears the used end;
// the header store is not cleared. The receiver cannot stall; results last one cycle.
// ============================================================================
// first_fit_heap_allocator_top: first-fit heap allocator with block splitting
// Controller and datapath joined by command and status bundles.
// ============================================================================
module first_fit_heap_allocator_top #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  ffha_pkg::t_req                  i_item,
    output logic                            o_done,
    output ffha_pkg::t_rsp                  o_result,
    input  logic                            i_cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffha_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ffha_pkg::t_cmd w_cmd;
    ffha_pkg::t_sts w_sts;

    // Sequencer.
    ffha_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_item.opcode),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    // Header store and arithmetic.
    ffha_dp #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_done      (o_done),
        .o_result    (o_result)
    );

`ifndef SYNTH
    // An accepted beat always leaves the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not make the block busy");

    // A result beat follows a busy cycle.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result beat without prior work");

    // Result beats never come back to back.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two result beats in a row");

    // Out of memory and freed results carry a zero address.
    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ffha_pkg::ST_OOM ||
                    o_result.status == ffha_pkg::ST_FREED))
        |-> (o_result.data_address == '0))
        else $error("nonzero address on a result without a block");
`endif

endmodule

### hdl/ffha_dp.sv
// ============================================================================
// ffha_dp: datapath of the first-fit heap allocator
// Configuration registers, header store memories, walk offset, request
// size registers, append bookkeeping and the registered result beat.
// ============================================================================
module ffha_dp #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ffha_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  ffha_pkg::t_req                      i_item,
    input  ffha_pkg::t_cmd                      i_cmd,
    output ffha_pkg::t_sts                      o_sts,
    output logic                                o_done,
    output ffha_pkg::t_rsp                      o_result
);

    localparam int SIZE_W = ffha_pkg::SIZE_W;
    localparam int ADDR_W = ffha_pkg::ADDR_W;
    localparam int SZ8_W  = ffha_pkg::SZ8_W;
    localparam int OFF_W  = $clog2(HEAP_BYTES + 1);
    localparam int IDX_W  = $clog2(HEAP_BYTES);
    localparam int WALK_W = $clog2(HEAP_BYTES + (1 << SIZE_W) + HEADER_BYTES + 1);
    localparam int CMP_W  = WALK_W + 1;

    localparam logic [CMP_W-1:0]  HEAP_CMP  = CMP_W'(HEAP_BYTES);
    localparam logic [ADDR_W-1:0] HEAP_ADDR = ADDR_W'(HEAP_BYTES);
    localparam logic [ADDR_W-1:0] HB_ADDR   = ADDR_W'(HEADER_BYTES);
    localparam logic [SZ8_W-1:0]  HB_SZ8    = SZ8_W'(HEADER_BYTES);
    localparam logic [WALK_W-1:0] HB_WALK   = WALK_W'(HEADER_BYTES);

    // Configuration registers.
    logic [ADDR_W-1:0]             r_heap_base;
    logic [ffha_pkg::LIMIT_W-1:0]  r_heap_limit;
    logic [ffha_pkg::MINBLK_W-1:0] r_min_block;

    // Allocator state and per-request working registers.
    logic [OFF_W-1:0]  r_used_end;
    logic [ADDR_W-1:0] r_addr;
    logic [SIZE_W-1:0] r_size;
    logic [SZ8_W-1:0]  r_sz8;
    logic [SZ8_W-1:0]  r_need;
    logic [WALK_W-1:0] r_off;
    logic              r_rd_free;
    logic [SIZE_W-1:0] r_rd_size;
    logic              r_done;
    ffha_pkg::t_rsp    r_result;

    // Header store: free flags and payload sizes, one entry per byte offset.
    logic              r_mem_free [HEAP_BYTES];
    logic [SIZE_W-1:0] r_mem_size [HEAP_BYTES];

    logic [SIZE_W-1:0] n_size;
    logic [SZ8_W-1:0]  n_thresh;
    logic [SZ8_W-1:0]  n_sz8;
    logic [SZ8_W-1:0]  n_need;
    logic [WALK_W-1:0] n_off;
    logic              next_ok;
    logic [WALK_W-1:0] split_off;
    logic              split_ok;
    logic [SZ8_W-1:0]  split_diff;
    logic [CMP_W-1:0]  off_cmp;
    logic [CMP_W-1:0]  used_cmp;
    logic [CMP_W-1:0]  limit_cfg;
    logic [CMP_W-1:0]  limit_eff;
    logic [CMP_W-1:0]  used_next;
    logic [ADDR_W-1:0] free_off;
    logic              free_ok;
    logic [ADDR_W-1:0] res_off;
    logic [ADDR_W-1:0] res_addr;

    logic              flag_we;
    logic [IDX_W-1:0]  flag_idx;
    logic              flag_wd;
    logic              size_we;
    logic [IDX_W-1:0]  size_idx;
    logic [SIZE_W-1:0] size_wd;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;

    // Request size raised to the minimum, plus the split and append thresholds.
    always_comb begin
        n_size   = (i_item.request_size < SIZE_W'(r_min_block)) ?
                   SIZE_W'(r_min_block) : i_item.request_size;
        n_thresh = (SZ8_W'(r_min_block) < HB_SZ8) ? HB_SZ8 : SZ8_W'(r_min_block);
        n_sz8    = SZ8_W'(n_size) + HB_SZ8;
        n_need   = SZ8_W'(n_size) + n_thresh;
    end

    // Walk status for the header read in the previous cycle, and the room
    // check for an append below the effective limit.
    always_comb begin
        off_cmp        = CMP_W'(r_off);
        used_cmp       = CMP_W'(r_used_end);
        n_off          = r_off + HB_WALK + WALK_W'(r_rd_size);
        next_ok        = CMP_W'(n_off) < HEAP_CMP;
        split_off      = r_off + WALK_W'(r_sz8);
        split_ok       = CMP_W'(split_off) < HEAP_CMP;
        split_diff     = SZ8_W'(r_rd_size) - r_sz8;
        o_sts.walk_end = (off_cmp >= used_cmp) || (off_cmp >= HEAP_CMP);
        o_sts.fit      = r_rd_free && (r_rd_size >= r_size);
        o_sts.split    = SZ8_W'(r_rd_size) >= r_need;
        limit_cfg      = CMP_W'(r_heap_limit);
        limit_eff      = (limit_cfg < HEAP_CMP) ? limit_cfg : HEAP_CMP;
        used_next      = used_cmp + CMP_W'(r_sz8);
        o_sts.room     = (used_cmp <= limit_eff) && (used_next <= limit_eff);
    end

    // Header offset addressed by a free.
    always_comb begin
        free_off = r_addr - r_heap_base - HB_ADDR;
        free_ok  = free_off < HEAP_ADDR;
    end

    // Header store write and read port selection.
    always_comb begin
        flag_we  = 1'b0;
        flag_idx = r_off[IDX_W-1:0];
        flag_wd  = 1'b0;
        size_we  = 1'b0;
        size_idx = r_off[IDX_W-1:0];
        size_wd  = r_size;
        if (i_cmd.take) begin
            flag_we = 1'b1;
            size_we = o_sts.split;
        end else if (i_cmd.split_wr) begin
            flag_we  = split_ok;
            flag_idx = split_off[IDX_W-1:0];
            flag_wd  = 1'b1;
            size_we  = split_ok;
            size_idx = split_off[IDX_W-1:0];
            size_wd  = split_diff[SIZE_W-1:0];
        end else if (i_cmd.append) begin
            flag_we  = 1'b1;
            flag_idx = r_used_end[IDX_W-1:0];
            size_we  = 1'b1;
            size_idx = r_used_end[IDX_W-1:0];
        end else if (i_cmd.free_wr) begin
            flag_we  = free_ok;
            flag_idx = free_off[IDX_W-1:0];
            flag_wd  = 1'b1;
        end
        rd_en  = i_cmd.accept || (i_cmd.advance && next_ok);
        rd_idx = i_cmd.accept ? '0 : n_off[IDX_W-1:0];
    end

    // Header store memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (flag_we) begin
            r_mem_free[flag_idx] <= flag_wd;
        end
        if (size_we) begin
            r_mem_size[size_idx] <= size_wd;
        end
        if (rd_en) begin
            r_rd_free <= r_mem_free[rd_idx];
            r_rd_size <= r_mem_size[rd_idx];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_heap_limit <= ffha_pkg::HEAP_LIMIT_RST;
            r_min_block  <= ffha_pkg::MIN_BLOCK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ffha_pkg::CFG_HEAP_BASE:  r_heap_base  <= i_cfg_data;
                ffha_pkg::CFG_HEAP_LIMIT: r_heap_limit <= i_cfg_data[ffha_pkg::LIMIT_W-1:0];
                ffha_pkg::CFG_MIN_BLOCK:  r_min_block  <= i_cfg_data[ffha_pkg::MINBLK_W-1:0];
                default: ;
            endcase
        end
    end

    // End of the used region.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_end <= '0;
        end else if (i_cmd.append) begin
            r_used_end <= used_next[OFF_W-1:0];
        end
    end

    // Working registers for the request in flight.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr <= i_item.block_address;
            r_size <= n_size;
            r_sz8  <= n_sz8;
            r_need <= n_need;
            r_off  <= '0;
        end else if (i_cmd.advance) begin
            r_off  <= n_off;
        end
    end

    // Result beat, shown for one cycle.
    always_comb begin
        res_off  = i_cmd.append ? ADDR_W'(r_used_end) : ADDR_W'(r_off);
        res_addr = r_heap_base + HB_ADDR + res_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result.status <= i_cmd.emit_status;
            if (i_cmd.emit_status == ffha_pkg::ST_REUSED ||
                i_cmd.emit_status == ffha_pkg::ST_APPENDED) begin
                r_result.data_address <= res_addr;
            end else begin
                r_result.data_address <= '0;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### hdl/ffha_ctrl.sv
// ============================================================================
// ffha_ctrl: controller of the first-fit heap allocator
// Sequences accept, the header walk, the split write, the append decision
// and the free write, and issues the result beat.
// ============================================================================
module ffha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_opcode,
    input  ffha_pkg::t_sts i_sts,
    output ffha_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    ffha_pkg::t_state r_state;
    ffha_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ffha_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_opcode == ffha_pkg::OP_FREE) ?
                              ffha_pkg::S_FREE : ffha_pkg::S_WALK;
                end
            end
            ffha_pkg::S_FREE: begin
                o_cmd.free_wr     = 1'b1;
                o_cmd.emit        = 1'b1;
                o_cmd.emit_status = ffha_pkg::ST_FREED;
                n_state           = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_WALK: begin
                if (i_sts.walk_end) begin
                    n_state = ffha_pkg::S_TAIL;
                end else if (i_sts.fit) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.split) begin
                        n_state = ffha_pkg::S_SPLIT;
                    end else begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ffha_pkg::ST_REUSED;
                        n_state           = ffha_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            ffha_pkg::S_SPLIT: begin
                o_cmd.split_wr    = 1'b1;
                o_cmd.emit        = 1'b1;
                o_cmd.emit_status = ffha_pkg::ST_REUSED;
                n_state           = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_TAIL: begin
                o_cmd.emit = 1'b1;
                if (i_sts.room) begin
                    o_cmd.append      = 1'b1;
                    o_cmd.emit_status = ffha_pkg::ST_APPENDED;
                end else begin
                    o_cmd.emit_status = ffha_pkg::ST_OOM;
                end
                n_state = ffha_pkg::S_IDLE;
            end
            default: begin
                n_state = ffha_pkg::S_IDLE;
            end
        endcase
    end

endmodule
